FILE: rtl/rational_add_reduce_unit_macros.svh
// Assertion macros for the rational add/reduce unit.
`ifndef RATIONAL_ADD_REDUCE_UNIT_MACROS_SVH
`define RATIONAL_ADD_REDUCE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define RAR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAR_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAR_ASSERT(label, clk, rst_n, prop, msg)
`define RAR_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/rar_pkg.sv
// Shared types and constants for the rational add/reduce unit.
package rar_pkg;
  localparam int NUM_W = 32;
  localparam int DEN_W = 31;
  localparam int EXT_W = 64;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Item as classified by the front end
  typedef struct packed {
    logic             a_neg;
    logic [NUM_W-1:0] a_mag;
    logic [DEN_W-1:0] a_den;
    logic             b_neg;
    logic [NUM_W-1:0] b_mag;
    logic [DEN_W-1:0] b_den;
    logic             zero_den;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_G1, S_LCM_DIV, S_LCM_MUL, S_SCA_DIV, S_SCB_DIV, S_SCALE,
    S_ADD, S_G2, S_RED_N, S_RED_D, S_CHECK, S_OUT
  } bstate_t;
endpackage

FILE: rtl/rational_add_reduce_unit.sv
// Top level of the rational add/reduce unit.
// channel | direction | ports
// in      | in        | in_valid, in_stall, in_a_num, in_a_den, in_b_num, in_b_den
// out     | out       | out_valid, out_stall, out_sum_num, out_sum_den, out_status
// Each divider pass goes through the start register, the operand load, the quotient bits and done.
// A zero denominator item skips the divider. Any other item takes the first Euclid loop
// plus three quotients and, unless its sum is zero, the second Euclid loop and two more quotients.
// All of this work shares the single bit-serial 64-bit divider.
// Reset clears both queue pointers and the back end state; no clearing pass.
// The front queue holds two items, so input is taken while the back end works.
module rational_add_reduce_unit import rar_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [NUM_W-1:0] in_a_num,
  input  logic [DEN_W-1:0] in_a_den,
  input  logic [NUM_W-1:0] in_b_num,
  input  logic [DEN_W-1:0] in_b_den,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [NUM_W-1:0] out_sum_num,
  output logic [DEN_W-1:0] out_sum_den,
  output logic [1:0]       out_status
);
  logic  q_valid, q_pop;
  item_t q_item;

  rar_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num),
    .in_b_den(in_b_den), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  rar_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_sum_num(out_sum_num),
    .out_sum_den(out_sum_den), .out_status(out_status)
  );
endmodule

FILE: rtl/rar_divider.sv
// Restoring divider, one quotient bit per cycle, 64-bit operands.
module rar_divider import rar_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [EXT_W-1:0] dividend,
  input  logic [EXT_W-1:0] divisor,
  output logic             done,
  output logic [EXT_W-1:0] quot,
  output logic [EXT_W-1:0] rem
);
  logic [EXT_W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [EXT_W:0]   trial;
  logic [EXT_W:0]   shifted;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {r_r, q_r[EXT_W-1]};
    trial    = shifted - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[EXT_W]) begin
        r_nxt = trial[EXT_W-1:0];
        q_nxt = {q_r[EXT_W-2:0], 1'b1};
      end else begin
        r_nxt = shifted[EXT_W-1:0];
        q_nxt = {q_r[EXT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(EXT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule

FILE: rtl/rar_front.sv
// Front end: takes items, splits signs, flags zero denominators, two-entry queue.
module rar_front import rar_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [NUM_W-1:0] in_a_num,
  input  logic [DEN_W-1:0] in_a_den,
  input  logic [NUM_W-1:0] in_b_num,
  input  logic [DEN_W-1:0] in_b_den,
  output logic             q_valid,
  output item_t            q_item,
  input  logic             q_pop
);
  `include "rational_add_reduce_unit_macros.svh"
  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.a_neg    = in_a_num[NUM_W-1];
    cls.a_mag    = in_a_num[NUM_W-1] ? (~in_a_num + 1'b1) : in_a_num;
    cls.a_den    = in_a_den;
    cls.b_neg    = in_b_num[NUM_W-1];
    cls.b_mag    = in_b_num[NUM_W-1] ? (~in_b_num + 1'b1) : in_b_num;
    cls.b_den    = in_b_den;
    cls.zero_den = (in_a_den == '0) || (in_b_den == '0);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) mem_r[wp_r] <= cls;
  end

  `RAR_ASSERT(a_no_overfill, clk, rst_n, cnt_r <= 2'd2, "queue count out of range")
  `RAR_ASSERT(a_pop_nonempty, clk, rst_n, q_pop |-> q_valid, "pop from empty queue")
  `RAR_ASSERT(a_push_count, clk, rst_n, (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1,
              "push not counted")
endmodule

FILE: rtl/rar_back.sv
// Back end: LCM scaling, signed add, GCD reduction and range check.
module rar_back import rar_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [NUM_W-1:0] out_sum_num,
  output logic [DEN_W-1:0] out_sum_den,
  output logic [1:0]       out_status
);
  `include "rational_add_reduce_unit_macros.svh"
  localparam logic [EXT_W-1:0] LIM = EXT_W'(64'd1 << (WORD_BITS - 1));

  bstate_t st_r, st_nxt;
  item_t   it_r, it_nxt;
  logic [EXT_W-1:0] x_r, x_nxt, y_r, y_nxt, lcm_r, lcm_nxt, ta_r, ta_nxt;
  logic [EXT_W-1:0] tb_r, tb_nxt, sm_r, sm_nxt, g_r, g_nxt, rd_r, rd_nxt;
  logic [EXT_W-1:0] fa_r, fa_nxt;
  logic             rn_r, rn_nxt, dv_go;
  logic [EXT_W-1:0] dv_a, dv_b, dv_q, dv_rem;
  logic             dv_done, dv_go_r, dv_go_nxt;
  logic [NUM_W-1:0] on_r, on_nxt;
  logic [DEN_W-1:0] od_r, od_nxt;
  status_t          os_r, os_nxt;
  logic [63:0]      prod;
  logic [31:0]      mul_a, mul_b;

  rar_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_go), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(dv_q), .rem(dv_rem)
  );

  assign dv_go = dv_go_r;
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    st_nxt = st_r; it_nxt = it_r; x_nxt = x_r; y_nxt = y_r; lcm_nxt = lcm_r;
    ta_nxt = ta_r; tb_nxt = tb_r; sm_nxt = sm_r; g_nxt = g_r; rd_nxt = rd_r;
    fa_nxt = fa_r; rn_nxt = rn_r; on_nxt = on_r; od_nxt = od_r; os_nxt = os_r;
    dv_go_nxt = 1'b0; dv_a = x_r; dv_b = y_r; q_pop = 1'b0;
    mul_a = '0; mul_b = '0;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          it_nxt = q_item;
          if (q_item.zero_den) begin
            on_nxt = '0; od_nxt = '0; os_nxt = ST_ZERO_DEN; st_nxt = S_OUT;
          end else begin
            x_nxt = EXT_W'(q_item.a_den); y_nxt = EXT_W'(q_item.b_den);
            dv_go_nxt = 1'b1; st_nxt = S_G1;
          end
        end
      end
      S_G1: begin
        // Euclid: x mod y per divider pass
        if (dv_done) begin
          if (dv_rem == '0) begin
            g_nxt = y_r; x_nxt = EXT_W'(it_r.a_den); y_nxt = y_r;
            dv_go_nxt = 1'b1; st_nxt = S_LCM_DIV;
          end else begin
            x_nxt = y_r; y_nxt = dv_rem; dv_go_nxt = 1'b1;
          end
        end
      end
      S_LCM_DIV: if (dv_done) begin
        x_nxt = dv_q; st_nxt = S_LCM_MUL;
      end
      S_LCM_MUL: begin
        mul_a = x_r[31:0]; mul_b = 32'(it_r.b_den);
        lcm_nxt = prod; x_nxt = prod; y_nxt = EXT_W'(it_r.a_den);
        dv_go_nxt = 1'b1; st_nxt = S_SCA_DIV;
      end
      S_SCA_DIV: if (dv_done) begin
        fa_nxt = dv_q; x_nxt = lcm_r; y_nxt = EXT_W'(it_r.b_den);
        dv_go_nxt = 1'b1; st_nxt = S_SCB_DIV;
      end
      S_SCB_DIV: if (dv_done) begin
        tb_nxt = dv_q; st_nxt = S_SCALE;
        mul_a = fa_r[31:0]; mul_b = it_r.a_mag; ta_nxt = prod;
      end
      S_SCALE: begin
        mul_a = tb_r[31:0]; mul_b = it_r.b_mag; tb_nxt = prod; st_nxt = S_ADD;
      end
      S_ADD: begin
        if (it_r.a_neg == it_r.b_neg) begin
          sm_nxt = ta_r + tb_r; rn_nxt = it_r.a_neg;
        end else if (ta_r >= tb_r) begin
          sm_nxt = ta_r - tb_r; rn_nxt = it_r.a_neg;
        end else begin
          sm_nxt = tb_r - ta_r; rn_nxt = it_r.b_neg;
        end
        if (sm_nxt == '0) begin
          on_nxt = '0; od_nxt = DEN_W'(1); os_nxt = ST_OK; st_nxt = S_OUT;
        end else begin
          x_nxt = lcm_r; y_nxt = sm_nxt; dv_go_nxt = 1'b1; st_nxt = S_G2;
        end
      end
      S_G2: if (dv_done) begin
        if (dv_rem == '0) begin
          g_nxt = y_r; x_nxt = sm_r; y_nxt = y_r; dv_go_nxt = 1'b1; st_nxt = S_RED_N;
        end else begin
          x_nxt = y_r; y_nxt = dv_rem; dv_go_nxt = 1'b1;
        end
      end
      S_RED_N: if (dv_done) begin
        sm_nxt = dv_q; x_nxt = lcm_r; y_nxt = g_r; dv_go_nxt = 1'b1; st_nxt = S_RED_D;
      end
      S_RED_D: if (dv_done) begin
        rd_nxt = dv_q; st_nxt = S_CHECK;
      end
      S_CHECK: begin
        st_nxt = S_OUT;
        if (rd_r > LIM - 1'b1 || (rn_r ? (sm_r > LIM) : (sm_r > LIM - 1'b1))) begin
          on_nxt = '0; od_nxt = '0; os_nxt = ST_OVERFLOW;
        end else begin
          on_nxt = rn_r ? (~sm_r[NUM_W-1:0] + 1'b1) : sm_r[NUM_W-1:0];
          od_nxt = rd_r[DEN_W-1:0]; os_nxt = ST_OK;
        end
      end
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      dv_go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      dv_go_r <= dv_go_nxt;
    end
    it_r <= it_nxt; x_r <= x_nxt; y_r <= y_nxt; lcm_r <= lcm_nxt; ta_r <= ta_nxt;
    tb_r <= tb_nxt; sm_r <= sm_nxt; g_r <= g_nxt; rd_r <= rd_nxt; fa_r <= fa_nxt;
    rn_r <= rn_nxt; on_r <= on_nxt; od_r <= od_nxt; os_r <= os_nxt;
  end

  assign out_valid   = (st_r == S_OUT);
  assign out_sum_num = on_r;
  assign out_sum_den = od_r;
  assign out_status  = os_r;

  `RAR_ASSERT(a_hold_out, clk, rst_n, (out_valid && out_stall) |=> out_valid,
              "result dropped while stalled")
  `RAR_ASSERT(a_err_zero, clk, rst_n,
              (out_valid && out_status != ST_OK) |-> (out_sum_den == '0 && out_sum_num == '0),
              "error result not zeroed")
  `RAR_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !out_valid, "output valid after reset")
endmodule

FILE: sim/tb_rational_add_reduce_unit.sv
// Self-checking testbench for the rational add/reduce unit: fraction sums in lowest terms.
`timescale 1ns / 1ps
module tb_rational_add_reduce_unit;
  import rar_pkg::*;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    status_t          status;
  } sum_t;

  int err_cnt = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_cnt++;
  endtask

  class sum_scoreboard;
    sum_t pending[$];
    int   n_in, n_out, n_zero_den, n_ovf;

    static function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    // exact sum over the lcm, reduced, then range checked at 32 bits
    function void note_input(logic [31:0] an_raw, logic [30:0] ad_raw,
                             logic [31:0] bn_raw, logic [30:0] bd_raw);
      sum_t s;
      logic an, bn, rn;
      logic [63:0] am, bm, ad, bd, g, lcm, ta, tb, sm, rd;
      an = an_raw[31];
      bn = bn_raw[31];
      am = an ? 64'h1_0000_0000 - an_raw : {32'd0, an_raw};
      bm = bn ? 64'h1_0000_0000 - bn_raw : {32'd0, bn_raw};
      ad = ad_raw;
      bd = bd_raw;
      n_in++;
      s = '{num: '0, den: '0, status: ST_OK};
      if (ad == 0 || bd == 0) begin
        s.status = ST_ZERO_DEN;
        n_zero_den++;
      end else begin
        g = gcd64(ad, bd);
        lcm = (ad / g) * bd;
        ta = am * (lcm / ad);
        tb = bm * (lcm / bd);
        if (an == bn) begin
          sm = ta + tb; rn = an;
        end else if (ta >= tb) begin
          sm = ta - tb; rn = an;
        end else begin
          sm = tb - ta; rn = bn;
        end
        if (sm == 0) begin
          s.den = 1;
        end else begin
          g = gcd64(lcm, sm);
          sm = sm / g;
          rd = lcm / g;
          if (rd > 64'h7FFF_FFFF || (rn ? sm > 64'h8000_0000 : sm > 64'h7FFF_FFFF)) begin
            s.status = ST_OVERFLOW;
            n_ovf++;
          end else begin
            s.num = rn ? 32'(64'h1_0000_0000 - sm) : sm[31:0];
            s.den = rd[30:0];
          end
        end
      end
      pending.push_back(s);
    endfunction

    task check_result(logic [31:0] num, logic [30:0] den, logic [1:0] st);
      sum_t w;
      n_out++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected transfer", {num, 1'b0, den}, 64'd0);
        return;
      end
      w = pending.pop_front();
      if (num !== w.num) report_mismatch("sum_num", 64'(num), 64'(w.num));
      if (den !== w.den) report_mismatch("sum_den", 64'(den), 64'(w.den));
      if (st !== w.status) report_mismatch("status", 64'(st), 64'(w.status));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [NUM_W-1:0] in_a_num = 0, in_b_num = 0, out_sum_num;
  logic [DEN_W-1:0] in_a_den = 0, in_b_den = 0, out_sum_den;
  logic [1:0] out_status;
  int send_idle_pct = 0, stall_pct = 0;
  sum_scoreboard sb = new();

  rational_add_reduce_unit u_dut (.*);

  initial forever #6 clk = ~clk;

  initial begin
    #400ms;
    $display("rational_add_reduce_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_sum_num, out_sum_den, out_status);
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // valid stays high between back-to-back transfers; it drops only for idle cycles
  task automatic send_fraction_pair(logic [31:0] an, logic [30:0] ad,
                                    logic [31:0] bn, logic [30:0] bd);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1;
    in_a_num <= an; in_a_den <= ad; in_b_num <= bn; in_b_den <= bd;
    do @(posedge clk); while (in_stall);
    sb.note_input(an, ad, bn, bd);
  endtask

  function automatic logic [30:0] rand_den();
    case ($urandom_range(3))
      0: return 31'($urandom_range(12, 1));
      1: return 31'($urandom_range(1000, 1));
      2: return 31'($urandom_range(65535, 1));
      default: return 31'($urandom) | 31'd1;
    endcase
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(3))
      0: return 32'($urandom_range(40)) - 32'd20;
      1: return 32'($urandom_range(200000)) - 32'd100000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] n;
    logic [30:0] d;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // zero denominators, zero sum, extremes, overflow and sign cases
    send_fraction_pair(5, 0, 3, 7);
    send_fraction_pair(5, 7, 3, 0);
    send_fraction_pair(0, 0, 0, 0);
    send_fraction_pair(3, 4, -32'sd3, 4);
    send_fraction_pair(0, 1, 0, 31'h7FFF_FFFF);
    send_fraction_pair(32'h8000_0000, 1, 0, 1);
    send_fraction_pair(32'h8000_0000, 1, 32'h8000_0000, 1);
    send_fraction_pair(32'h7FFF_FFFF, 1, 1, 1);
    send_fraction_pair(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
    send_fraction_pair(32'h8000_0000, 1, -32'sd1, 1);
    send_fraction_pair(32'h8000_0000, 2, 32'h8000_0000, 2);
    send_fraction_pair(1, 31'h7FFF_FFFF, 1, 31'h7FFF_FFFE);
    send_fraction_pair(1, 31'h7FFF_FFFF, 1, 31'h7FFF_FFFF);
    send_fraction_pair(32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_fraction_pair(2, 6, 4, 6);
    send_fraction_pair(-32'sd1, 3, 1, 6);
    send_fraction_pair(32'hAAAA_AAAA, 31'h5555_5555, 32'h5555_5555, 31'h2AAA_AAAA);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 27 : 81) : 0;
      stall_pct     = (ph == 2 || ph == 3) ? (ph == 3 ? 27 : 81) : 0;
      for (int i = 0; i < 100; i++) begin
        d = rand_den();
        n = rand_num();
        if ($urandom_range(19) == 0)
          send_fraction_pair(n, $urandom_range(1) ? 31'd0 : d, rand_num(), rand_den());
        else if ($urandom_range(9) == 0)
          send_fraction_pair(n, d, -n, d);  // cancels to zero
        else
          send_fraction_pair(n, d, rand_num(), rand_den());
      end
    end
    in_valid <= 0;
    stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d fraction pairs sent, %0d sums checked", sb.n_in, sb.n_out);
    $display("%0d zero-denominator and %0d overflow cases seen", sb.n_zero_den, sb.n_ovf);
    if (err_cnt == 0)
      $display("rational_add_reduce_unit regression: pass");
    else
      $display("rational_add_reduce_unit regression: fail");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/rar_pkg.sv
rtl/rar_divider.sv
rtl/rar_front.sv
rtl/rar_back.sv
rtl/rational_add_reduce_unit.sv
sim/tb_rational_add_reduce_unit.sv
